// ===== sv/cmm_pkg.sv =====
package cmm_pkg;

    localparam int CountWidth = 24;
    localparam int LabelWidth = 16;
    localparam int FracBits   = 16;
    localparam int RatioWidth = FracBits + 1;
    localparam int MccWidth   = FracBits + 2;
    // numerator and denominator widths for the shared divider
    localparam int NumWidth   = CountWidth + 3 + FracBits;
    localparam int DenWidth   = CountWidth + 3;
    localparam int ProdWidth  = 2 * CountWidth;
    localparam int FacWidth   = CountWidth + 1;
    localparam int DenAWidth  = 2 * FacWidth;
    localparam int DenBWidth  = 4 * FacWidth;
    localparam int SqCandWidth = 2 * ProdWidth;
    localparam int RemWidth   = DenBWidth + 1;
    localparam int MqWidth    = 2 * FracBits + 1;
    localparam int SqWidth    = 2 * (FracBits + 1);

    localparam int RatioCount = 6;
    localparam int RatioIdxW  = $clog2(RatioCount);
    localparam int DivStepW   = $clog2(NumWidth + 1);
    localparam int SrchStepW  = $clog2(FracBits + 2);
    localparam int MulStepW   = $clog2(DenAWidth);
    localparam int MdivStepW  = $clog2(MqWidth);

    // ratio slots
    localparam logic [RatioIdxW-1:0] RatSens = RatioIdxW'(0);
    localparam logic [RatioIdxW-1:0] RatSpec = RatioIdxW'(1);
    localparam logic [RatioIdxW-1:0] RatPrec = RatioIdxW'(2);
    localparam logic [RatioIdxW-1:0] RatNpv  = RatioIdxW'(3);
    localparam logic [RatioIdxW-1:0] RatF1   = RatioIdxW'(4);
    localparam logic [RatioIdxW-1:0] RatMiss = RatioIdxW'(5);

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD_RATIO,
        OP_DIV_STEP,
        OP_STORE_RATIO,
        OP_MCC_PREP,
        OP_MCC_PREP2,
        OP_MUL_STEP,
        OP_MDIV_STEP,
        OP_SRCH_STEP,
        OP_DONE
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic [RatioIdxW-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic div_last;
        logic mul_last;
        logic mdiv_last;
        logic srch_last;
    } t_status;

endpackage

// ===== sv/cmm_datapath.sv =====
module cmm_datapath
    import cmm_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_count_en,
    input  logic                         i_clear,
    input  logic [LabelWidth-1:0]        i_actual_label,
    input  logic [LabelWidth-1:0]        i_predicted_label,
    input  logic [LabelWidth-1:0]        i_pos_class,
    input  t_cmd                         i_cmd,
    output t_status                      o_status,
    output logic [CountWidth-1:0]        o_true_pos,
    output logic [CountWidth-1:0]        o_true_neg,
    output logic [CountWidth-1:0]        o_false_pos,
    output logic [CountWidth-1:0]        o_false_neg,
    output logic [RatioWidth-1:0]        o_sensitivity,
    output logic [RatioWidth-1:0]        o_specificity,
    output logic [RatioWidth-1:0]        o_precision,
    output logic [RatioWidth-1:0]        o_neg_pred_value,
    output logic [RatioWidth-1:0]        o_f1_score,
    output logic [RatioWidth-1:0]        o_balanced_acc,
    output logic [RatioWidth-1:0]        o_misclass_rate,
    output logic signed [MccWidth-1:0]   o_matthews_corr
);

    localparam logic [CountWidth-1:0] CountMax = '1;
    localparam logic [FracBits:0]     SrchMax  = {1'b1, {FracBits{1'b0}}};

    logic [CountWidth-1:0] r_tp, r_tn, r_fp, r_fn;
    logic act, prd;

    assign act = (i_actual_label == i_pos_class);
    assign prd = (i_predicted_label == i_pos_class);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_tp <= '0;
            r_tn <= '0;
            r_fp <= '0;
            r_fn <= '0;
        end else if (i_count_en) begin
            if (act && prd) begin
                if (r_tp != CountMax) r_tp <= r_tp + 1'b1;
            end else if (!act && !prd) begin
                if (r_tn != CountMax) r_tn <= r_tn + 1'b1;
            end else if (prd) begin
                if (r_fp != CountMax) r_fp <= r_fp + 1'b1;
            end else begin
                if (r_fn != CountMax) r_fn <= r_fn + 1'b1;
            end
        end
    end

    // ratio operand select
    logic [DenWidth-1:0] sel_num, sel_den;
    always_comb begin
        sel_num = '0;
        sel_den = '0;
        case (i_cmd.idx)
            RatSens: begin
                sel_num = DenWidth'(r_tp);
                sel_den = DenWidth'(r_tp) + DenWidth'(r_fn);
            end
            RatSpec: begin
                sel_num = DenWidth'(r_tn);
                sel_den = DenWidth'(r_tn) + DenWidth'(r_fp);
            end
            RatPrec: begin
                sel_num = DenWidth'(r_tp);
                sel_den = DenWidth'(r_tp) + DenWidth'(r_fp);
            end
            RatNpv: begin
                sel_num = DenWidth'(r_tn);
                sel_den = DenWidth'(r_tn) + DenWidth'(r_fn);
            end
            RatF1: begin
                sel_num = DenWidth'({r_tp, 1'b0});
                sel_den = DenWidth'({r_tp, 1'b0}) + DenWidth'(r_fp) + DenWidth'(r_fn);
            end
            RatMiss: begin
                sel_num = DenWidth'(r_fp) + DenWidth'(r_fn);
                sel_den = DenWidth'(r_tp) + DenWidth'(r_tn) + DenWidth'(r_fp)
                        + DenWidth'(r_fn);
            end
            default: ;
        endcase
    end

    // restoring divider, one quotient bit per cycle
    logic [NumWidth-1:0] r_quo;
    logic [DenWidth:0]   r_rem;
    logic [DenWidth-1:0] r_den;
    logic [DivStepW-1:0] r_div_cnt;
    logic [DenWidth:0]   rem_sh;
    logic                rem_ge;

    assign rem_sh = {r_rem[DenWidth-1:0], r_quo[NumWidth-1]};
    assign rem_ge = rem_sh >= {1'b0, r_den};

    // mcc registers
    logic [ProdWidth-1:0]   r_p1, r_p2;
    logic [ProdWidth-1:0]   mnum;
    logic                   r_mneg;
    logic [DenAWidth-1:0]   r_da, r_db;
    // shift-and-add multipliers for num^2 and the full denominator
    logic [SqCandWidth-1:0] r_sq_cand;
    logic [ProdWidth-1:0]   r_sq_mult;
    logic [RemWidth-1:0]    r_mrem;
    logic [DenBWidth-1:0]   r_dcand;
    logic [DenAWidth-1:0]   r_dmult;
    logic [DenBWidth-1:0]   r_dfull;
    logic [MulStepW-1:0]    r_mul_cnt;
    // num^2 * 2^(2*FracBits) / den, one quotient bit per cycle
    logic [MqWidth-1:0]     r_mq;
    logic [MdivStepW-1:0]   r_mdiv_cnt;
    logic [RemWidth-1:0]    mrem_sh;
    logic                   mrem_ge;
    logic [FracBits:0]      r_lo, r_hi;
    logic [SrchStepW-1:0]   r_srch_cnt;
    logic                   r_mzero;
    logic [FacWidth-1:0]    f1, f2, f3, f4;
    logic [FracBits+1:0]    mid_w;
    logic [FracBits:0]      mid;
    logic [SqWidth-1:0]     r_sq;
    logic [FracBits:0]      r_mid;
    logic                   r_sq_vld;

    assign f1 = FacWidth'(r_tp) + FacWidth'(r_fp);
    assign f2 = FacWidth'(r_tp) + FacWidth'(r_fn);
    assign f3 = FacWidth'(r_tn) + FacWidth'(r_fp);
    assign f4 = FacWidth'(r_tn) + FacWidth'(r_fn);
    assign mnum = (r_p1 < r_p2) ? r_p2 - r_p1 : r_p1 - r_p2;
    assign mid_w = ({1'b0, r_lo} + {1'b0, r_hi} + 1'b1) >> 1;
    assign mid = mid_w[FracBits:0];
    // num^2 never exceeds the denominator, so the first step takes no shift
    assign mrem_sh = (r_mdiv_cnt == '0) ? r_mrem : {r_mrem[DenBWidth-1:0], 1'b0};
    assign mrem_ge = mrem_sh >= {1'b0, r_dfull};

    logic [RatioWidth-1:0] r_ratio [RatioCount];
    logic [RatioWidth:0]   bal_sum;

    // search alternates between squaring the probe and comparing the square
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld <= 1'b0;
        end else begin
            r_sq_vld <= (i_cmd.op == OP_SRCH_STEP) && !r_sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD_RATIO: begin
                r_quo     <= {sel_num, {FracBits{1'b0}}};
                r_rem     <= '0;
                r_den     <= sel_den;
                r_div_cnt <= '0;
            end
            OP_DIV_STEP: begin
                r_quo     <= {r_quo[NumWidth-2:0], rem_ge};
                r_rem     <= rem_ge ? rem_sh - {1'b0, r_den} : rem_sh;
                r_div_cnt <= r_div_cnt + 1'b1;
            end
            OP_STORE_RATIO: begin
                r_ratio[i_cmd.idx] <= (r_den == '0) ? '0 : r_quo[RatioWidth-1:0];
            end
            OP_MCC_PREP: begin
                r_p1    <= r_tp * r_tn;
                r_p2    <= r_fp * r_fn;
                r_da    <= f1 * f2;
                r_db    <= f3 * f4;
                r_mzero <= (f1 == '0) || (f2 == '0) || (f3 == '0) || (f4 == '0);
            end
            OP_MCC_PREP2: begin
                r_mneg     <= r_p1 < r_p2;
                r_sq_cand  <= SqCandWidth'(mnum);
                r_sq_mult  <= mnum;
                r_mrem     <= '0;
                r_dcand    <= DenBWidth'(r_da);
                r_dmult    <= r_db;
                r_dfull    <= '0;
                r_mul_cnt  <= '0;
                r_mdiv_cnt <= '0;
                r_lo       <= '0;
                r_hi       <= SrchMax;
                r_srch_cnt <= '0;
            end
            OP_MUL_STEP: begin
                r_mrem    <= r_mrem + (r_sq_mult[0] ? RemWidth'(r_sq_cand) : '0);
                r_sq_cand <= r_sq_cand << 1;
                r_sq_mult <= r_sq_mult >> 1;
                r_dfull   <= r_dfull + (r_dmult[0] ? r_dcand : '0);
                r_dcand   <= r_dcand << 1;
                r_dmult   <= r_dmult >> 1;
                r_mul_cnt <= r_mul_cnt + 1'b1;
            end
            OP_MDIV_STEP: begin
                r_mq       <= {r_mq[MqWidth-2:0], mrem_ge};
                r_mrem     <= mrem_ge ? mrem_sh - {1'b0, r_dfull} : mrem_sh;
                r_mdiv_cnt <= r_mdiv_cnt + 1'b1;
            end
            OP_SRCH_STEP: begin
                if (!r_sq_vld) begin
                    // first half of the step: square the probe
                    r_mid <= mid;
                    r_sq  <= SqWidth'(mid) * SqWidth'(mid);
                end else begin
                    if (r_sq <= SqWidth'(r_mq)) r_lo <= r_mid;
                    else r_hi <= r_mid - 1'b1;
                    r_srch_cnt <= r_srch_cnt + 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_status.div_last  = (r_div_cnt == DivStepW'(NumWidth - 1));
    assign o_status.mul_last  = (r_mul_cnt == MulStepW'(DenAWidth - 1));
    assign o_status.mdiv_last = (r_mdiv_cnt == MdivStepW'(MqWidth - 1));
    assign o_status.srch_last = (r_srch_cnt == SrchStepW'(FracBits + 1));

    assign bal_sum = {1'b0, r_ratio[RatSens]} + {1'b0, r_ratio[RatSpec]};

    assign o_true_pos       = r_tp;
    assign o_true_neg       = r_tn;
    assign o_false_pos      = r_fp;
    assign o_false_neg      = r_fn;
    assign o_sensitivity    = r_ratio[RatSens];
    assign o_specificity    = r_ratio[RatSpec];
    assign o_precision      = r_ratio[RatPrec];
    assign o_neg_pred_value = r_ratio[RatNpv];
    assign o_f1_score       = r_ratio[RatF1];
    assign o_misclass_rate  = r_ratio[RatMiss];
    assign o_balanced_acc   = bal_sum[RatioWidth:1];
    assign o_matthews_corr  = r_mzero ? '0 :
        (r_mneg ? -$signed({1'b0, r_lo}) : $signed({1'b0, r_lo}));

endmodule

// ===== sv/cmm_ctrl.sv =====
module cmm_ctrl
    import cmm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  logic    i_last,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy,
    output logic    o_clear,
    output logic    o_done
);

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_DIV, S_STORE, S_PREP, S_PREP2, S_MUL, S_MDIV, S_SRCH, S_OUT
    } t_state;

    t_state               r_state, n_state;
    logic [RatioIdxW-1:0] r_idx, n_idx;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_cmd   = '{op: OP_NONE, idx: r_idx};
        unique case (r_state)
            S_IDLE: begin
                if (i_accept && i_last) begin
                    n_state = S_LOAD;
                    n_idx   = '0;
                end
            end
            S_LOAD: begin
                o_cmd.op = OP_LOAD_RATIO;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = OP_DIV_STEP;
                if (i_status.div_last) n_state = S_STORE;
            end
            S_STORE: begin
                o_cmd.op = OP_STORE_RATIO;
                if (r_idx == RatioIdxW'(RatioCount - 1)) begin
                    n_state = S_PREP;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_LOAD;
                end
            end
            S_PREP: begin
                o_cmd.op = OP_MCC_PREP;
                n_state  = S_PREP2;
            end
            S_PREP2: begin
                o_cmd.op = OP_MCC_PREP2;
                n_state  = S_MUL;
            end
            S_MUL: begin
                o_cmd.op = OP_MUL_STEP;
                if (i_status.mul_last) n_state = S_MDIV;
            end
            S_MDIV: begin
                o_cmd.op = OP_MDIV_STEP;
                if (i_status.mdiv_last) n_state = S_SRCH;
            end
            S_SRCH: begin
                o_cmd.op = OP_SRCH_STEP;
                if (i_status.srch_last) begin
                    o_cmd.op = OP_NONE;
                    n_state  = S_OUT;
                end
            end
            S_OUT: begin
                o_cmd.op = OP_DONE;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_done  = (r_state == S_OUT);
    assign o_clear = (r_state == S_OUT);

endmodule

// ===== sv/confusion_matrix_metrics_unit.sv =====
// after the last sample is accepted the unit computes the six ratios in turn,
// then runs the mcc setup, the multiply, the divide and the square-root search,
// and raises o_result_valid in the output state; the receiver cannot stall
// throughput: one sample per cycle while counting; busy holds off start
// from the last sample until the result has been given
// reset: synchronous active low, clears counters, sets the positive label to 1
module confusion_matrix_metrics_unit
    import cmm_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [LabelWidth-1:0]      i_actual_label,
    input  logic [LabelWidth-1:0]      i_predicted_label,
    input  logic                       i_last_sample,
    output logic                       o_result_valid,
    output logic [CountWidth-1:0]      o_true_pos,
    output logic [CountWidth-1:0]      o_true_neg,
    output logic [CountWidth-1:0]      o_false_pos,
    output logic [CountWidth-1:0]      o_false_neg,
    output logic [RatioWidth-1:0]      o_sensitivity,
    output logic [RatioWidth-1:0]      o_specificity,
    output logic [RatioWidth-1:0]      o_precision,
    output logic [RatioWidth-1:0]      o_neg_pred_value,
    output logic [RatioWidth-1:0]      o_f1_score,
    output logic [RatioWidth-1:0]      o_balanced_acc,
    output logic [RatioWidth-1:0]      o_misclass_rate,
    output logic signed [MccWidth-1:0] o_matthews_corr,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [1:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam logic [1:0] AddrPosClass = 2'd0;

    logic [LabelWidth-1:0] r_pos_class;
    logic    accept, clear, done;
    t_cmd    cmd;
    t_status status;

    assign pready = 1'b1;
    assign prdata = (paddr == AddrPosClass) ? 32'(r_pos_class) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_class <= LabelWidth'(1);
        end else if (psel && penable && pwrite && paddr == AddrPosClass) begin
            r_pos_class <= pwdata[LabelWidth-1:0];
        end
    end

    assign accept = start && !busy;

    cmm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_last   (i_last_sample),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_clear  (clear),
        .o_done   (done)
    );

    cmm_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_count_en        (accept),
        .i_clear           (clear),
        .i_actual_label    (i_actual_label),
        .i_predicted_label (i_predicted_label),
        .i_pos_class       (r_pos_class),
        .i_cmd             (cmd),
        .o_status          (status),
        .o_true_pos        (o_true_pos),
        .o_true_neg        (o_true_neg),
        .o_false_pos       (o_false_pos),
        .o_false_neg       (o_false_neg),
        .o_sensitivity     (o_sensitivity),
        .o_specificity     (o_specificity),
        .o_precision       (o_precision),
        .o_neg_pred_value  (o_neg_pred_value),
        .o_f1_score        (o_f1_score),
        .o_balanced_acc    (o_balanced_acc),
        .o_misclass_rate   (o_misclass_rate),
        .o_matthews_corr   (o_matthews_corr)
    );

    assign o_result_valid = done;

endmodule

// ===== sv/cmm_checker.sv =====
module cmm_checker
    import cmm_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  i_last_sample,
    input logic                  o_result_valid,
    input logic [RatioWidth-1:0] o_sensitivity,
    input logic [RatioWidth-1:0] o_balanced_acc
);

    // a result closes the computation, so busy drops right after
    a_res_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !busy) else $error("busy after result");

    // a result only appears while busy
    a_res_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> busy) else $error("result while idle");

    // a non-last accepted sample never starts the computation
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_last_sample) |=> !busy) else $error("spurious busy");

    a_ratio_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_sensitivity <= RatioWidth'(1 << FracBits)))
        else $error("ratio range");

    a_bal_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_balanced_acc <= RatioWidth'(1 << FracBits)))
        else $error("balanced accuracy range");

endmodule

bind confusion_matrix_metrics_unit cmm_checker u_cmm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_last_sample  (i_last_sample),
    .o_result_valid (o_result_valid),
    .o_sensitivity  (o_sensitivity),
    .o_balanced_acc (o_balanced_acc)
);
